/* src/dhkv_pkg.sv */
// Package with shared constants and types of the double-hash key-value table.
package dhkv_pkg;

  localparam int unsigned TableDepth = 2048;
  localparam int unsigned KeyChars   = 7;
  localparam int unsigned KeyW       = 56;
  localparam int unsigned ValW       = 16;
  localparam int unsigned SizeW      = 12;

  localparam logic [1:0] ModeInsert = 2'd0;
  localparam logic [1:0] ModeSearch = 2'd1;
  localparam logic [1:0] ModeDelete = 2'd2;

  localparam logic [2:0] StInserted = 3'd0;
  localparam logic [2:0] StFound    = 3'd1;
  localparam logic [2:0] StNotFound = 3'd2;
  localparam logic [2:0] StDeleted  = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  localparam logic [1:0] SlotEmpty   = 2'd0;
  localparam logic [1:0] SlotUsed    = 2'd1;
  localparam logic [1:0] SlotDeleted = 2'd2;

  localparam logic CfgTableSize  = 1'b0;
  localparam logic CfgHashChoice = 1'b1;

  // Result of the hash unit toward the prober.
  typedef struct packed {
    logic [SizeW-1:0] home;
    logic [SizeW-1:0] step;
  } hash_res_t;

endpackage

/* src/dhkv_hash.sv */
// Sequential home and step hash unit, one key byte per round of shift-subtract reductions.
module dhkv_hash #(
  parameter int unsigned KeyChars = dhkv_pkg::KeyChars
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [8*KeyChars-1:0]   key_i,
  input  logic [11:0]             n_i,
  input  logic                    choice_i,
  output logic                    done_o,
  output dhkv_pkg::hash_res_t     res_o
);

  localparam int unsigned CntW = $clog2(KeyChars + 1);
  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhLoad = 3'd1;
  localparam logic [2:0] PhTerm = 3'd2;
  localparam logic [2:0] PhMul  = 3'd3;
  localparam logic [2:0] PhRed  = 3'd4;
  localparam logic [2:0] PhAcc  = 3'd5;
  localparam logic [2:0] PhDone = 3'd6;

  logic [2:0]            ph_q, ph_d;
  logic [CntW-1:0]       idx_q, idx_d;
  logic [3:0]            bit_q, bit_d;
  logic [8*KeyChars-1:0] key_q, key_d;
  logic [11:0]           h_q, h_d, s_q, s_d, g_q, g_d, p_q, p_d;
  logic [23:0]           ra_q, ra_d, rb_q, rb_d, rc_q, rc_d;
  logic [12:0]           acc_c;

  // One restoring step: subtract n shifted left by b when it fits.
  function automatic logic [23:0] red_step(input logic [23:0] v, input logic [11:0] n,
                                           input logic [3:0] b);
    logic [23:0] d;
    d = {12'd0, n} << b;
    return (v >= d) ? v - d : v;
  endfunction

  // Every value reduced here is below n * 2^12, so twelve steps (bit 11 down to 0)
  // leave a residue below n.
  always_comb begin
    ph_d = ph_q; idx_d = idx_q; bit_d = bit_q; key_d = key_q;
    h_d = h_q; s_d = s_q; g_d = g_q; p_d = p_q;
    ra_d = ra_q; rb_d = rb_q; rc_d = rc_q;
    acc_c = '0;
    unique case (ph_q)
      PhIdle: begin
        if (start_i) begin
          key_d = key_i; idx_d = '0; h_d = '0; s_d = '0;
          g_d = choice_i ? ((n_i == 12'd2) ? 12'd0 : 12'd2) : 12'd1;
          p_d = 12'd1;
          ph_d = PhLoad;
        end
      end
      PhLoad: begin
        // (c - 96) mod n is taken as (c + 128 n - 96) mod n, which never goes negative.
        ra_d = {16'd0, key_q[7:0]} + ({12'd0, n_i} << 7) - 24'd96;
        rb_d = {12'd0, s_q} + {16'd0, key_q[7:0]};
        bit_d = 4'd11;
        ph_d = PhTerm;
      end
      PhTerm: begin
        ra_d = red_step(ra_q, n_i, bit_q);
        rb_d = red_step(rb_q, n_i, bit_q);
        bit_d = bit_q - 4'd1;
        if (bit_q == 4'd0) ph_d = PhMul;
      end
      PhMul: begin
        s_d  = rb_q[11:0];
        ra_d = {12'd0, g_q} * {12'd0, ra_q[11:0]};
        rb_d = {12'd0, g_q} * (choice_i ? 24'd883 : 24'd701);
        rc_d = {12'd0, p_q} * 24'd26;
        bit_d = 4'd11;
        ph_d = PhRed;
      end
      PhRed: begin
        ra_d = red_step(ra_q, n_i, bit_q);
        rb_d = red_step(rb_q, n_i, bit_q);
        rc_d = red_step(rc_q, n_i, bit_q);
        bit_d = bit_q - 4'd1;
        if (bit_q == 4'd0) ph_d = PhAcc;
      end
      PhAcc: begin
        acc_c = {1'b0, h_q} + {1'b0, ra_q[11:0]};
        if (acc_c >= {1'b0, n_i}) acc_c = acc_c - {1'b0, n_i};
        if (choice_i) begin
          acc_c = acc_c + {1'b0, p_q};
          if (acc_c >= {1'b0, n_i}) acc_c = acc_c - {1'b0, n_i};
        end
        h_d = acc_c[11:0];
        g_d = rb_q[11:0];
        p_d = rc_q[11:0];
        key_d = key_q >> 8;
        idx_d = idx_q + CntW'(1);
        if (idx_q == CntW'(KeyChars - 1)) ph_d = PhDone;
        else ph_d = PhLoad;
      end
      default: ph_d = PhIdle;
    endcase
  end

  assign done_o = (ph_q == PhDone);
  assign res_o.home = h_q;
  assign res_o.step = s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhIdle;
      idx_q <= '0;
    end else begin
      ph_q <= ph_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d; key_q <= key_d; h_q <= h_d; s_q <= s_d; g_q <= g_d; p_q <= p_d;
    ra_q <= ra_d; rb_q <= rb_d; rc_q <= rc_d;
  end

endmodule

/* src/double_hash_key_value_table_unit.sv */
// Top level of the double-hash key-value table.
// One transaction at a time: after reset a clearing pass empties the slot-state memory,
// during which no transaction is taken. Each transaction then runs the hash unit
// (seven key bytes, each through twelve-step shift-subtract modular reductions, then
// a hand-over) and, unless the mode is unknown and reports not-found, a probe walk
// through the registered-read slot memories, with a read state and a check state per
// slot visited, up to the active table size in probes. Results sit in an output
// register so a new transaction can enter while the previous result waits; a finished
// result that finds that register still full waits until it drains.
module double_hash_key_value_table_unit #(
  parameter int unsigned TableDepth = dhkv_pkg::TableDepth,
  parameter int unsigned KeyChars   = dhkv_pkg::KeyChars
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [11:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            mode_i,
  input  logic [8*KeyChars-1:0] key_i,
  input  logic [15:0]           value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            status_o,
  output logic [15:0]           found_value_o
);

  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned KW = 8 * KeyChars;
  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SHash  = 3'd2;
  localparam logic [2:0] SRead  = 3'd3;
  localparam logic [2:0] SCheck = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  logic [2:0]  st_q, st_d;
  logic [11:0] size_q;
  logic        choice_q;
  logic [1:0]  mode_q;
  logic [KW-1:0] key_q;
  logic [15:0] val_q;
  logic [11:0] pos_q, pos_d, step_q, step_d, cnt_q, cnt_d;
  logic [AW:0] clr_q;
  logic        ov_q;
  logic [2:0]  stat_q, stat_d, out_stat_q;
  logic [15:0] fv_q, fv_d, out_fv_q;
  logic [11:0] n_c, nxt_c;
  logic [12:0] sum_c;
  logic [AW-1:0] addr_c;
  logic        hstart, hdone, load_c;
  dhkv_pkg::hash_res_t hres;

  logic [KW-1:0] mkey [TableDepth];
  logic [15:0]   mval [TableDepth];
  logic [1:0]    mst  [TableDepth];
  logic [KW-1:0] rkey_q;
  logic [15:0]   rval_q;
  logic [1:0]    rst_q;
  logic          we_st, we_kv;
  logic [1:0]    wst;

  // The active size never exceeds 4095 or TableDepth, so it always fits 12 bits.
  always_comb begin
    if (size_q < 12'd2) n_c = 12'd2;
    else if (32'(size_q) > TableDepth) n_c = 12'(TableDepth);
    else n_c = size_q;
  end

  // The hash unit latches the key straight from the port at the accepting edge.
  dhkv_hash #(.KeyChars(KeyChars)) u_hash (
    .clk_i, .rst_ni, .start_i(hstart), .key_i(key_i), .n_i(n_c),
    .choice_i(choice_q), .done_o(hdone), .res_o(hres)
  );

  assign in_ready_o = (st_q == SIdle);
  assign sum_c = {1'b0, pos_q} + {1'b0, step_q};
  assign nxt_c = (sum_c >= {1'b0, n_c}) ? 12'(sum_c - {1'b0, n_c}) : sum_c[11:0];
  assign addr_c = AW'(pos_q);
  // A finished result moves to the output register once that register is free.
  assign load_c = (st_q == SDone) && (!ov_q || out_ready_i);

  always_comb begin
    st_d = st_q; pos_d = pos_q; step_d = step_q; cnt_d = cnt_q;
    stat_d = stat_q; fv_d = fv_q; hstart = 1'b0;
    we_st = 1'b0; we_kv = 1'b0; wst = dhkv_pkg::SlotUsed;
    unique case (st_q)
      SClear: if (clr_q == (AW+1)'(TableDepth - 1)) st_d = SIdle;
      SIdle: if (in_valid_i && in_ready_o) begin
        st_d = SHash; hstart = 1'b1;
      end
      SHash: if (hdone) begin
        pos_d = hres.home; step_d = hres.step; cnt_d = '0; st_d = SRead;
        if (mode_q != dhkv_pkg::ModeInsert && mode_q != dhkv_pkg::ModeSearch &&
            mode_q != dhkv_pkg::ModeDelete) begin
          stat_d = dhkv_pkg::StNotFound; fv_d = '0; st_d = SDone;
        end
      end
      SRead: st_d = SCheck;
      SCheck: begin
        if (mode_q == dhkv_pkg::ModeInsert && rst_q != dhkv_pkg::SlotUsed) begin
          we_st = 1'b1; we_kv = 1'b1;
          stat_d = dhkv_pkg::StInserted; fv_d = '0; st_d = SDone;
        end else if (mode_q != dhkv_pkg::ModeInsert && rst_q == dhkv_pkg::SlotUsed &&
                     rkey_q == key_q) begin
          fv_d = '0;
          if (mode_q == dhkv_pkg::ModeSearch) begin
            stat_d = dhkv_pkg::StFound; fv_d = rval_q;
          end else begin
            we_st = 1'b1; wst = dhkv_pkg::SlotDeleted; stat_d = dhkv_pkg::StDeleted;
          end
          st_d = SDone;
        end else if (cnt_q + 12'd1 >= n_c) begin
          stat_d = (mode_q == dhkv_pkg::ModeInsert) ? dhkv_pkg::StFull
                                                    : dhkv_pkg::StNotFound;
          fv_d = '0; st_d = SDone;
        end else begin
          cnt_d = cnt_q + 12'd1; pos_d = nxt_c; st_d = SRead;
        end
      end
      SDone: if (load_c) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SClear) mst[clr_q[AW-1:0]] <= dhkv_pkg::SlotEmpty;
    else if (we_st) mst[addr_c] <= wst;
    if (we_kv) begin
      mkey[addr_c] <= key_q;
      mval[addr_c] <= val_q;
    end
    rst_q  <= mst[addr_c];
    rkey_q <= mkey[addr_c];
    rval_q <= mval[addr_c];
    pos_q <= pos_d; step_q <= step_d; cnt_q <= cnt_d;
    stat_q <= stat_d; fv_q <= fv_d;
    if (load_c) begin
      out_stat_q <= stat_q; out_fv_q <= fv_q;
    end
    if (in_valid_i && in_ready_o) begin
      mode_q <= mode_i; key_q <= key_i; val_q <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SClear; clr_q <= '0; ov_q <= 1'b0;
      size_q <= 12'd2048; choice_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == SClear) clr_q <= clr_q + (AW+1)'(1);
      if (load_c) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_index_i == dhkv_pkg::CfgTableSize) size_q <= cfg_data_i;
        else choice_q <= cfg_data_i[0];
      end
    end
  end

  assign out_valid_o = ov_q;
  assign status_o = out_stat_q;
  assign found_value_o = out_fv_q;

  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == SDone |=> out_valid_o) else $error("result not shown");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != SIdle |-> !in_ready_o) else $error("accepted while busy");
  a_fv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != dhkv_pkg::StFound |-> found_value_o == 16'd0)
    else $error("found_value not zero");

endmodule
